@@ design/hbp_pkg.sv @@
// Shared types, constants and helper functions for the hybrid branch predictor.
`timescale 1ns / 1ps
`default_nettype none

package hbp_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHOOSER_BITS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GSHARE_BITS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_BITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BIMODAL_BITS = 3'd4;

  // Predictor modes; bit 1 set selects the hybrid (mode three included)
  localparam logic [1:0] MODE_BIMODAL    = 2'd0;
  localparam logic [1:0] MODE_GSHARE     = 2'd1;
  localparam int         MODE_HYBRID_BIT = 1;

  // Register reset values
  localparam logic [3:0] CHOOSER_BITS_RST = 4'd12;
  localparam logic [3:0] GSHARE_BITS_RST  = 4'd12;
  localparam logic [3:0] HISTORY_BITS_RST = 4'd8;
  localparam logic [3:0] BIMODAL_BITS_RST = 4'd12;

  // 2-bit saturating counters
  localparam logic [1:0] CTR_MIN     = 2'd0;
  localparam logic [1:0] CTR_MAX     = 2'd3;
  localparam logic [1:0] BIM_CTR_RST = 2'd2;
  localparam logic [1:0] GSH_CTR_RST = 2'd2;
  localparam logic [1:0] CHO_CTR_RST = 2'd1;

  typedef struct packed {
    logic [31:0] branch_address;
    logic        taken;
  } branch_t;

  typedef struct packed {
    logic        predicted_taken;
    logic        mispredicted;
    logic        used_gshare;
    logic [31:0] prediction_count;
    logic [31:0] misprediction_count;
  } result_t;

  typedef struct packed {
    logic [1:0] predictor_mode;
    logic [3:0] chooser_index_bits;
    logic [3:0] gshare_index_bits;
    logic [3:0] history_bits;
    logic [3:0] bimodal_index_bits;
  } cfg_t;

  // Saturating step up or down
  function automatic logic [1:0] ctr_train(input logic [1:0] c, input logic up);
    logic [1:0] r;
    if (up) begin
      r = (c == CTR_MAX) ? c : c + 2'd1;
    end else begin
      r = (c == CTR_MIN) ? c : c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/hybrid_branch_predictor_top.sv @@
// Top level of the hybrid (bimodal / gshare / chooser) branch predictor.
`timescale 1ns / 1ps
`default_nettype none

// Takes one resolved branch word per cycle unless the result register is stalled, and
// returns one result word for each, in order (index and memory read in the accepting
// cycle; predict, train and write back when the update stage advances, which loads
// the result register at its end). The three counter tables are single-port-read
// memories with a registered read; the write of the previous branch is forwarded,
// so back-to-back branches to the same entry see each other's training. After
// reset the tables are swept to their reset values, one entry per cycle in all
// three at once; branch_ready stays low until the sweep ends. Configuration writes
// are taken at any time but should only be made while the predictor is idle.
module hybrid_branch_predictor_top import hbp_pkg::*; #(
  parameter int MAX_BIMODAL_BITS = 12,
  parameter int MAX_GSHARE_BITS  = 12,
  parameter int MAX_CHOOSER_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  branch_valid,
  output logic                       branch_ready,
  input  wire branch_t               branch,
  output logic                       result_valid,
  input  wire logic                  result_ready,
  output result_t                    result
);

  localparam int BG_AW  = (MAX_BIMODAL_BITS > MAX_GSHARE_BITS) ? MAX_BIMODAL_BITS
                                                               : MAX_GSHARE_BITS;
  localparam int CLR_AW = (BG_AW > MAX_CHOOSER_BITS) ? BG_AW : MAX_CHOOSER_BITS;

  cfg_t                        cfg;
  logic                        accept;
  logic                        s1_free;
  logic                        clearing;
  logic [CLR_AW-1:0]           clr_idx;
  logic [MAX_BIMODAL_BITS-1:0] bim_idx;
  logic [MAX_GSHARE_BITS-1:0]  gsh_idx;
  logic [MAX_CHOOSER_BITS-1:0] cho_idx;
  logic [1:0]                  bim_q;
  logic [1:0]                  gsh_q;
  logic [1:0]                  cho_q;
  logic                        bim_we_u;
  logic [MAX_BIMODAL_BITS-1:0] bim_wa_u;
  logic [1:0]                  bim_wd_u;
  logic                        gsh_we_u;
  logic [MAX_GSHARE_BITS-1:0]  gsh_wa_u;
  logic [1:0]                  gsh_wd_u;
  logic                        cho_we_u;
  logic [MAX_CHOOSER_BITS-1:0] cho_wa_u;
  logic [1:0]                  cho_wd_u;
  logic                        bim_we;
  logic [MAX_BIMODAL_BITS-1:0] bim_wa;
  logic [1:0]                  bim_wd;
  logic                        gsh_we;
  logic [MAX_GSHARE_BITS-1:0]  gsh_wa;
  logic [1:0]                  gsh_wd;
  logic                        cho_we;
  logic [MAX_CHOOSER_BITS-1:0] cho_wa;
  logic [1:0]                  cho_wd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.predictor_mode     <= MODE_BIMODAL;
      cfg.chooser_index_bits <= CHOOSER_BITS_RST;
      cfg.gshare_index_bits  <= GSHARE_BITS_RST;
      cfg.history_bits       <= HISTORY_BITS_RST;
      cfg.bimodal_index_bits <= BIMODAL_BITS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:         cfg.predictor_mode     <= cfg_data[1:0];
        REG_CHOOSER_BITS: cfg.chooser_index_bits <= cfg_data;
        REG_GSHARE_BITS:  cfg.gshare_index_bits  <= cfg_data;
        REG_HISTORY_BITS: cfg.history_bits       <= cfg_data;
        REG_BIMODAL_BITS: cfg.bimodal_index_bits <= cfg_data;
        default: ;
      endcase
    end
  end

  // Table clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + CLR_AW'(1);
      if (&clr_idx) begin
        clearing <= 1'b0;
      end
    end
  end

  assign branch_ready = !clearing && s1_free;
  assign accept       = branch_valid && branch_ready;

  hbp_index #(
    .BIM_AW (MAX_BIMODAL_BITS),
    .GSH_AW (MAX_GSHARE_BITS),
    .CHO_AW (MAX_CHOOSER_BITS)
  ) u_index (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .accept         (accept),
    .branch_address (branch.branch_address),
    .taken          (branch.taken),
    .bim_idx        (bim_idx),
    .gsh_idx        (gsh_idx),
    .cho_idx        (cho_idx)
  );

  hbp_update #(
    .BIM_AW (MAX_BIMODAL_BITS),
    .GSH_AW (MAX_GSHARE_BITS),
    .CHO_AW (MAX_CHOOSER_BITS)
  ) u_update (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .bim_idx      (bim_idx),
    .gsh_idx      (gsh_idx),
    .cho_idx      (cho_idx),
    .taken        (branch.taken),
    .bim_q        (bim_q),
    .gsh_q        (gsh_q),
    .cho_q        (cho_q),
    .s1_free      (s1_free),
    .bim_we       (bim_we_u),
    .bim_wa       (bim_wa_u),
    .bim_wd       (bim_wd_u),
    .gsh_we       (gsh_we_u),
    .gsh_wa       (gsh_wa_u),
    .gsh_wd       (gsh_wd_u),
    .cho_we       (cho_we_u),
    .cho_wa       (cho_wa_u),
    .cho_wd       (cho_wd_u),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // Write port: sweep during clearing, training otherwise
  always_comb begin
    if (clearing) begin
      bim_we = 1'b1;
      bim_wa = clr_idx[MAX_BIMODAL_BITS-1:0];
      bim_wd = BIM_CTR_RST;
      gsh_we = 1'b1;
      gsh_wa = clr_idx[MAX_GSHARE_BITS-1:0];
      gsh_wd = GSH_CTR_RST;
      cho_we = 1'b1;
      cho_wa = clr_idx[MAX_CHOOSER_BITS-1:0];
      cho_wd = CHO_CTR_RST;
    end else begin
      bim_we = bim_we_u;
      bim_wa = bim_wa_u;
      bim_wd = bim_wd_u;
      gsh_we = gsh_we_u;
      gsh_wa = gsh_wa_u;
      gsh_wd = gsh_wd_u;
      cho_we = cho_we_u;
      cho_wa = cho_wa_u;
      cho_wd = cho_wd_u;
    end
  end

  hbp_counter_ram #(.AW(MAX_BIMODAL_BITS)) u_bim_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (bim_idx),
    .wr_en   (bim_we),
    .wr_addr (bim_wa),
    .wr_data (bim_wd),
    .rd_data (bim_q)
  );

  hbp_counter_ram #(.AW(MAX_GSHARE_BITS)) u_gsh_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (gsh_idx),
    .wr_en   (gsh_we),
    .wr_addr (gsh_wa),
    .wr_data (gsh_wd),
    .rd_data (gsh_q)
  );

  hbp_counter_ram #(.AW(MAX_CHOOSER_BITS)) u_cho_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (cho_idx),
    .wr_en   (cho_we),
    .wr_addr (cho_wa),
    .wr_data (cho_wd),
    .rd_data (cho_q)
  );

endmodule

`default_nettype wire

@@ design/hbp_counter_ram.sv @@
// Counter table: synchronous memory with registered read and write forwarding.
`timescale 1ns / 1ps
`default_nettype none

module hbp_counter_ram #(
  parameter int AW = 12
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [1:0]    wr_data,
  output logic      [1:0]    rd_data
);

  logic [1:0]    mem [2**AW];
  logic [1:0]    rdata;
  logic [AW-1:0] rd_addr_q;
  logic          lw_valid;
  logic [AW-1:0] lw_addr;
  logic [1:0]    lw_data;

  // Memory array: read returns old data on a same-address write
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata     <= mem[rd_addr];
      rd_addr_q <= rd_addr;
    end
  end

  // Last write, kept so a read that raced it sees the new value
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (wr_en) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      lw_addr <= wr_addr;
      lw_data <= wr_data;
    end
  end

  assign rd_data = (lw_valid && lw_addr == rd_addr_q) ? lw_data : rdata;

endmodule

`default_nettype wire

@@ design/hbp_index.sv @@
// Index generation for the three tables and the global history register.
`timescale 1ns / 1ps
`default_nettype none

module hbp_index import hbp_pkg::*; #(
  parameter int BIM_AW = 12,
  parameter int GSH_AW = 12,
  parameter int CHO_AW = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic [31:0]       branch_address,
  input  wire logic              taken,
  output logic      [BIM_AW-1:0] bim_idx,
  output logic      [GSH_AW-1:0] gsh_idx,
  output logic      [CHO_AW-1:0] cho_idx
);

  localparam int BCW = $clog2(BIM_AW + 1);
  localparam int GCW = $clog2(GSH_AW + 1);
  localparam int CCW = $clog2(CHO_AW + 1);

  logic [29:0]       pc;
  logic [BCW-1:0]    m2;
  logic [GCW-1:0]    m1;
  logic [GCW-1:0]    n;
  logic [GCW-1:0]    s;
  logic [CCW-1:0]    k;
  logic [BIM_AW-1:0] bim_mask;
  logic [GSH_AW-1:0] gsh_mask;
  logic [GSH_AW-1:0] hist_mask;
  logic [CHO_AW-1:0] cho_mask;
  logic [GSH_AW-1:0] history;
  logic [GSH_AW-1:0] history_next;
  logic [GSH_AW-1:0] hist_n;
  logic [GSH_AW-1:0] hist_shr;

  assign pc = branch_address[31:2];

  // Clamp widths to table sizes; history to the gshare width
  always_comb begin
    m2 = (int'(cfg.bimodal_index_bits) > BIM_AW) ? BCW'(BIM_AW)
                                                 : BCW'(cfg.bimodal_index_bits);
    m1 = (int'(cfg.gshare_index_bits) > GSH_AW) ? GCW'(GSH_AW)
                                                : GCW'(cfg.gshare_index_bits);
    k  = (int'(cfg.chooser_index_bits) > CHO_AW) ? CCW'(CHO_AW)
                                                 : CCW'(cfg.chooser_index_bits);
    n  = (int'(cfg.history_bits) > int'(m1)) ? m1 : GCW'(cfg.history_bits);
    s  = m1 - n;
  end

  // Low-bit masks
  always_comb begin
    for (int i = 0; i < BIM_AW; i++) bim_mask[i] = (i < int'(m2));
    for (int i = 0; i < GSH_AW; i++) gsh_mask[i] = (i < int'(m1));
    for (int i = 0; i < GSH_AW; i++) hist_mask[i] = (i < int'(n));
    for (int i = 0; i < CHO_AW; i++) cho_mask[i] = (i < int'(k));
  end

  // History folds into the upper n bits of the gshare index
  assign hist_n  = history & hist_mask;
  assign bim_idx = pc[BIM_AW-1:0] & bim_mask;
  assign cho_idx = pc[CHO_AW-1:0] & cho_mask;
  assign gsh_idx = (pc[GSH_AW-1:0] & gsh_mask) ^ (hist_n << s);

  // Shift right, outcome enters at bit n-1; n of zero leaves all clear
  assign hist_shr = hist_n >> 1;
  always_comb begin
    for (int i = 0; i < GSH_AW; i++) begin
      history_next[i] = (i + 1 == int'(n)) ? taken : hist_shr[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history <= '0;
    end else if (accept && cfg.predictor_mode != MODE_BIMODAL) begin
      history <= history_next;
    end
  end

endmodule

`default_nettype wire

@@ design/hbp_update.sv @@
// Predict-and-train stage: table write-back, running counts and result register.
`timescale 1ns / 1ps
`default_nettype none

module hbp_update import hbp_pkg::*; #(
  parameter int BIM_AW = 12,
  parameter int GSH_AW = 12,
  parameter int CHO_AW = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cfg_t              cfg,
  input  wire logic              accept,
  input  wire logic [BIM_AW-1:0] bim_idx,
  input  wire logic [GSH_AW-1:0] gsh_idx,
  input  wire logic [CHO_AW-1:0] cho_idx,
  input  wire logic              taken,
  input  wire logic [1:0]        bim_q,
  input  wire logic [1:0]        gsh_q,
  input  wire logic [1:0]        cho_q,
  output logic                   s1_free,
  output logic                   bim_we,
  output logic      [BIM_AW-1:0] bim_wa,
  output logic      [1:0]        bim_wd,
  output logic                   gsh_we,
  output logic      [GSH_AW-1:0] gsh_wa,
  output logic      [1:0]        gsh_wd,
  output logic                   cho_we,
  output logic      [CHO_AW-1:0] cho_wa,
  output logic      [1:0]        cho_wd,
  output logic                   result_valid,
  input  wire logic              result_ready,
  output result_t                result
);

  logic              s1_valid;
  logic [BIM_AW-1:0] s1_bi;
  logic [GSH_AW-1:0] s1_gi;
  logic [CHO_AW-1:0] s1_ci;
  logic              s1_taken;
  logic              adv;
  logic              bim_pred;
  logic              gsh_pred;
  logic              hybrid;
  logic              use_gshare;
  logic              pred;
  logic              miss;
  logic [31:0]       branches_seen;
  logic [31:0]       misses_seen;
  logic [31:0]       branches_seen_next;
  logic [31:0]       misses_seen_next;

  // Stage moves on when the result register is empty or being drained
  assign adv     = s1_valid && (!result_valid || result_ready);
  assign s1_free = !s1_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bi    <= bim_idx;
      s1_gi    <= gsh_idx;
      s1_ci    <= cho_idx;
      s1_taken <= taken;
    end
  end

  // Prediction and selection
  always_comb begin
    bim_pred   = bim_q[1];
    gsh_pred   = gsh_q[1];
    hybrid     = cfg.predictor_mode[MODE_HYBRID_BIT];
    use_gshare = hybrid ? cho_q[1] : (cfg.predictor_mode == MODE_GSHARE);
    pred       = use_gshare ? gsh_pred : bim_pred;
    miss       = pred != s1_taken;
  end

  // Write-back: only the predictor used trains; chooser, in hybrid mode, on disagreement
  always_comb begin
    bim_we = adv && !use_gshare;
    bim_wa = s1_bi;
    bim_wd = ctr_train(bim_q, s1_taken);
    gsh_we = adv && use_gshare;
    gsh_wa = s1_gi;
    gsh_wd = ctr_train(gsh_q, s1_taken);
    cho_we = adv && hybrid && (gsh_pred != bim_pred);
    cho_wa = s1_ci;
    cho_wd = ctr_train(cho_q, gsh_pred == s1_taken);
  end

  assign branches_seen_next = branches_seen + 32'd1;
  assign misses_seen_next   = miss ? misses_seen + 32'd1 : misses_seen;

  // Running counts
  always_ff @(posedge clk) begin
    if (rst) begin
      branches_seen <= '0;
      misses_seen   <= '0;
    end else if (adv) begin
      branches_seen <= branches_seen_next;
      misses_seen   <= misses_seen_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.predicted_taken     <= pred;
      result.mispredicted        <= miss;
      result.used_gshare         <= use_gshare;
      result.prediction_count    <= branches_seen_next;
      result.misprediction_count <= misses_seen_next;
    end
  end

endmodule

`default_nettype wire

@@ design/hbp_checker.sv @@
// Port-level checks for the branch predictor top, bound onto it.
`timescale 1ns / 1ps
`default_nettype none

module hbp_port_checker import hbp_pkg::*; (
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    branch_ready,
  input wire logic    result_valid,
  input wire logic    result_ready,
  input wire result_t result
);

  logic [31:0] words_out;

  // Count of result words taken so far
  always_ff @(posedge clk) begin
    if (rst) begin
      words_out <= '0;
    end else if (result_valid && result_ready) begin
      words_out <= words_out + 32'd1;
    end
  end

  // Nothing is taken or shown in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !branch_ready && !result_valid)
    else $error("ready or valid high straight after reset");

  // A stalled result word holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // Results come out in order, one count step apart, none lost
  a_count_seq: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.prediction_count == words_out + 32'd1)
    else $error("prediction count out of sequence");

  // Miss count steps only on a miss
  a_miss_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_ready ##1 result_valid |->
      result.misprediction_count ==
        $past(result.misprediction_count) + {31'd0, result.mispredicted})
    else $error("misprediction count out of step");

endmodule

bind hybrid_branch_predictor_top hbp_port_checker u_hbp_checker (.*);

`default_nettype wire

@@ tb/sv/hbp_checker.sv @@
// Checker for the hybrid branch predictor: mirrors its tables and compares result words.
`timescale 1ns / 1ps

module hbp_checker import hbp_pkg::*; #(
  parameter int MAX_BIMODAL_BITS = 12,
  parameter int MAX_GSHARE_BITS  = 12,
  parameter int MAX_CHOOSER_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  branch_valid,
  input  wire logic                  branch_ready,
  input  wire branch_t               branch,
  input  wire logic                  result_valid,
  input  wire logic                  result_ready,
  input  wire result_t               result,
  output int                         results_seen,
  output int                         failures
);

  // Shadow copy of the counter tables, history, running counts and registers
  logic [1:0]  bim_ctr [0:(1 << MAX_BIMODAL_BITS)-1];
  logic [1:0]  gsh_ctr [0:(1 << MAX_GSHARE_BITS)-1];
  logic [1:0]  cho_ctr [0:(1 << MAX_CHOOSER_BITS)-1];
  logic [31:0] ghist;
  logic [31:0] branch_total;
  logic [31:0] miss_total;
  cfg_t        shadow_cfg;

  // Outcomes worked out for accepted branches, oldest first
  result_t     verdict_q [$];
  result_t     want;

  function automatic logic [31:0] lsb_mask(input int w);
    return (32'd1 << w) - 32'd1;
  endfunction

  function automatic int clamp_width(input logic [3:0] w, input int lim);
    return (int'(w) > lim) ? lim : int'(w);
  endfunction

  // Two-bit counter step, held at the rails
  function automatic logic [1:0] nudge(input logic [1:0] c, input logic up);
    if (up && c != CTR_MAX) return c + 2'd1;
    if (!up && c != CTR_MIN) return c - 2'd1;
    return c;
  endfunction

  // Predicts one branch, trains the shadow tables and returns the result word
  function automatic result_t resolve_branch(input branch_t b);
    logic [31:0]                 pc, hist, gpc;
    logic [MAX_BIMODAL_BITS-1:0] bi;
    logic [MAX_GSHARE_BITS-1:0]  gi;
    logic [MAX_CHOOSER_BITS-1:0] ci;
    int          m1, m2, k, n, s;
    logic        bim_says, gsh_says, pick_gsh, guess;
    result_t     r;
    pc   = b.branch_address >> 2;
    m2   = clamp_width(shadow_cfg.bimodal_index_bits, MAX_BIMODAL_BITS);
    m1   = clamp_width(shadow_cfg.gshare_index_bits, MAX_GSHARE_BITS);
    k    = clamp_width(shadow_cfg.chooser_index_bits, MAX_CHOOSER_BITS);
    n    = (int'(shadow_cfg.history_bits) > m1) ? m1 : int'(shadow_cfg.history_bits);
    s    = m1 - n;
    hist = ghist & lsb_mask(n);
    bi   = MAX_BIMODAL_BITS'(pc & lsb_mask(m2));
    gpc  = pc & lsb_mask(m1);
    gi   = MAX_GSHARE_BITS'((((hist ^ (gpc >> s)) << s) | (gpc & lsb_mask(s)))
                            & lsb_mask(m1));
    ci   = MAX_CHOOSER_BITS'(pc & lsb_mask(k));
    // top bit of a counter set means taken (or gshare, for the chooser)
    bim_says = bim_ctr[bi][1];
    gsh_says = gsh_ctr[gi][1];

    if (shadow_cfg.predictor_mode[MODE_HYBRID_BIT]) begin
      pick_gsh = cho_ctr[ci][1];
      // chooser only learns when the two disagree
      if (gsh_says != bim_says) cho_ctr[ci] = nudge(cho_ctr[ci], gsh_says == b.taken);
    end else begin
      pick_gsh = (shadow_cfg.predictor_mode == MODE_GSHARE);
    end

    if (pick_gsh) begin
      guess       = gsh_says;
      gsh_ctr[gi] = nudge(gsh_ctr[gi], b.taken);
    end else begin
      guess       = bim_says;
      bim_ctr[bi] = nudge(bim_ctr[bi], b.taken);
    end

    branch_total = branch_total + 32'd1;
    if (guess != b.taken) miss_total = miss_total + 32'd1;

    // history moves in every mode but plain bimodal; outcome enters at the top
    if (shadow_cfg.predictor_mode != MODE_BIMODAL) begin
      if (n == 0) ghist = '0;
      else ghist = (hist >> 1) | ({31'd0, b.taken} << (n - 1));
    end

    r.predicted_taken     = guess;
    r.mispredicted        = (guess != b.taken);
    r.used_gshare         = pick_gsh;
    r.prediction_count    = branch_total;
    r.misprediction_count = miss_total;
    return r;
  endfunction

  // Watch the ports: register writes, accepted branches, returned result words
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < (1 << MAX_BIMODAL_BITS); i++) bim_ctr[i] = BIM_CTR_RST;
      for (int i = 0; i < (1 << MAX_GSHARE_BITS); i++) gsh_ctr[i] = GSH_CTR_RST;
      for (int i = 0; i < (1 << MAX_CHOOSER_BITS); i++) cho_ctr[i] = CHO_CTR_RST;
      ghist        = '0;
      branch_total = '0;
      miss_total   = '0;
      shadow_cfg   = '{predictor_mode: MODE_BIMODAL,
                       chooser_index_bits: CHOOSER_BITS_RST,
                       gshare_index_bits: GSHARE_BITS_RST,
                       history_bits: HISTORY_BITS_RST,
                       bimodal_index_bits: BIMODAL_BITS_RST};
      verdict_q.delete();
      results_seen <= 0;
      failures     <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:         shadow_cfg.predictor_mode     = cfg_data[1:0];
          REG_CHOOSER_BITS: shadow_cfg.chooser_index_bits = cfg_data;
          REG_GSHARE_BITS:  shadow_cfg.gshare_index_bits  = cfg_data;
          REG_HISTORY_BITS: shadow_cfg.history_bits       = cfg_data;
          REG_BIMODAL_BITS: shadow_cfg.bimodal_index_bits = cfg_data;
          default: ;
        endcase
      end

      if (branch_valid && branch_ready) verdict_q.push_back(resolve_branch(branch));

      if (result_valid && result_ready) begin
        results_seen <= results_seen + 1;
        if (verdict_q.size() == 0) begin
          if (failures < 10) $display("word %0d: result with no branch behind it", results_seen);
          failures <= failures + 1;
        end else begin
          want = verdict_q.pop_front();
          if (result !== want) begin
            if (failures < 10) begin
              $display("word %0d: exp pred %b miss %b gsh %b n %0d m %0d",
                       results_seen, want.predicted_taken, want.mispredicted,
                       want.used_gshare, want.prediction_count, want.misprediction_count);
              $display("word %0d: got pred %b miss %b gsh %b n %0d m %0d",
                       results_seen, result.predicted_taken, result.mispredicted,
                       result.used_gshare, result.prediction_count,
                       result.misprediction_count);
            end
            failures <= failures + 1;
          end
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench top for the hybrid branch predictor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top;
  import hbp_pkg::*;

  localparam int LONG_HOLD     = 160;
  localparam int POOL_SIZE     = 8;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_WORDS   = 50;

  localparam logic [1:0] MODE_HYBRID = 2'd1 << MODE_HYBRID_BIT;
  localparam logic [1:0] MODE_THREE  = MODE_HYBRID | MODE_GSHARE;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef enum int {HABIT_TAKEN, HABIT_NOT_TAKEN, HABIT_ALTERNATE, HABIT_RANDOM} habit_e;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;
  logic                  branch_valid = 1'b0;
  logic                  branch_ready;
  branch_t               branch       = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;

  int   results_seen;
  int   failures;
  int   branches_sent = 0;
  int   burst_left    = 0;
  logic hold_off_req  = 1'b0;

  logic [31:0] pool_addr [POOL_SIZE];
  habit_e      pool_habit [POOL_SIZE];
  logic        last_dir [POOL_SIZE];

  hybrid_branch_predictor_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .branch_valid (branch_valid),
    .branch_ready (branch_ready),
    .branch       (branch),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  hbp_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .branch_valid (branch_valid),
    .branch_ready (branch_ready),
    .branch       (branch),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .results_seen (results_seen),
    .failures     (failures)
  );

  always #1 clk = ~clk;

  // One branch word; bursts of random length with random gaps between them
  task automatic send_branch(input logic [31:0] addr, input logic outcome);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        branch_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    branch_valid <= 1'b1;
    branch       <= '{branch_address: addr, taken: outcome};
    @(posedge clk);
    while (!branch_ready) @(posedge clk);
    branches_sent++;
  endtask

  // Stop offering and wait for every outstanding result word
  task automatic drain();
    branch_valid <= 1'b0;
    while (results_seen != branches_sent) @(posedge clk);
  endtask

  task automatic poke_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  // Writes every register; the unused upper bits of the mode get random values
  task automatic apply_config(input cfg_t c);
    logic [1:0] junk;
    junk = 2'($urandom_range(0, 3));
    poke_reg(REG_MODE, {junk, c.predictor_mode});
    poke_reg(REG_CHOOSER_BITS, c.chooser_index_bits);
    poke_reg(REG_GSHARE_BITS, c.gshare_index_bits);
    poke_reg(REG_HISTORY_BITS, c.history_bits);
    poke_reg(REG_BIMODAL_BITS, c.bimodal_index_bits);
    cfg_we <= 1'b0;
  endtask

  // Index widths leaning on the edges: zero, one, table size, above it
  function automatic logic [3:0] pick_width();
    case ($urandom_range(0, 5))
      0:       return 4'd0;
      1:       return 4'd1;
      2:       return 4'd12;
      3:       return 4'd15;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  // Receiver: stretches of differing stall density, plus one long hold-off on request
  initial begin : receiver
    int   stretch;
    int   density;
    logic hold_done;
    hold_done = 1'b0;
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        stretch = $urandom_range(1, 40);
        density = $urandom_range(0, 3);
        for (int i = 0; i < stretch; i++) begin
          if (hold_off_req && !hold_done) break;
          case (density)
            0:       result_ready <= 1'b1;
            1:       result_ready <= 1'($urandom_range(0, 1));
            2:       result_ready <= ($urandom_range(0, 3) == 0);
            default: result_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Stimulus and verdict
  initial begin : stimulus
    cfg_t setting;
    int   sel;
    logic dir;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Bimodal at reset widths: address extremes, one entry pushed to both rails
    send_branch(32'h0000_0000, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    repeat (2) send_branch(32'h0000_0040, 1'b1);
    // same entry again, low address bits ignored
    repeat (4) send_branch(32'h0000_0043, 1'b0);
    drain();

    // Gshare, history longer than its index, zero-width bimodal and chooser
    apply_config('{predictor_mode: MODE_GSHARE, chooser_index_bits: 4'd0,
                   gshare_index_bits: 4'd4, history_bits: 4'd15, bimodal_index_bits: 4'd0});
    repeat (2) send_branch(32'h0000_0010, 1'b1);
    send_branch(32'h0000_0010, 1'b0);
    send_branch(32'hFFFF_FFFC, 1'b0);
    drain();

    // Mode three, widths above the table size, no history; stray index write
    poke_reg(REG_SPARE, 4'hF);
    apply_config('{predictor_mode: MODE_THREE, chooser_index_bits: 4'd15,
                   gshare_index_bits: 4'd15, history_bits: 4'd0, bimodal_index_bits: 4'd15});
    send_branch(32'h0000_0080, 1'b1);
    send_branch(32'h0000_0084, 1'b0);
    send_branch(32'h0000_0080, 1'b1);
    send_branch(32'h0000_0084, 1'b0);
    drain();

    // Hybrid with a single chooser entry and a one-bit gshare index
    apply_config('{predictor_mode: MODE_HYBRID, chooser_index_bits: 4'd0,
                   gshare_index_bits: 4'd1, history_bits: 4'd1, bimodal_index_bits: 4'd12});
    send_branch(32'h0000_0004, 1'b1);
    send_branch(32'h0000_0008, 1'b0);
    send_branch(32'h0000_0004, 1'b1);
    send_branch(32'h0000_0008, 1'b1);
    drain();

    // History frozen in bimodal mode, then picked up again by gshare
    apply_config('{predictor_mode: MODE_BIMODAL, chooser_index_bits: 4'd12,
                   gshare_index_bits: 4'd12, history_bits: 4'd8, bimodal_index_bits: 4'd12});
    repeat (2) send_branch(32'h0000_1234, 1'b1);
    drain();
    apply_config('{predictor_mode: MODE_GSHARE, chooser_index_bits: 4'd12,
                   gshare_index_bits: 4'd12, history_bits: 4'd8, bimodal_index_bits: 4'd12});
    send_branch(32'h0000_1234, 1'b0);
    send_branch(32'h0000_1238, 1'b1);
    drain();

    // Random phases: a pool of recurring branches with habits, some stray ones
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: setting = '{predictor_mode: MODE_HYBRID, chooser_index_bits: 4'd12,
                       gshare_index_bits: 4'd12, history_bits: 4'd12,
                       bimodal_index_bits: 4'd12};
        1: setting = '{predictor_mode: MODE_GSHARE, chooser_index_bits: 4'd0,
                       gshare_index_bits: 4'd0, history_bits: 4'd0,
                       bimodal_index_bits: 4'd0};
        2: setting = '{predictor_mode: MODE_THREE, chooser_index_bits: 4'd3,
                       gshare_index_bits: 4'd5, history_bits: 4'd15,
                       bimodal_index_bits: 4'd2};
        default: begin
          setting.predictor_mode     = 2'($urandom_range(0, 3));
          setting.chooser_index_bits = pick_width();
          setting.gshare_index_bits  = pick_width();
          setting.history_bits       = pick_width();
          setting.bimodal_index_bits = pick_width();
        end
      endcase
      apply_config(setting);

      for (int i = 0; i < POOL_SIZE; i++) begin
        pool_addr[i] = $urandom();
        // some entries alias the first one in every table
        if (i > 0 && $urandom_range(0, 2) == 0)
          pool_addr[i] = pool_addr[0] ^ (32'($urandom_range(1, 255)) << 16);
        pool_habit[i] = habit_e'($urandom_range(0, 3));
        last_dir[i]   = 1'($urandom_range(0, 1));
      end

      // long receiver hold-off while words keep coming
      if (ph == 3) hold_off_req <= 1'b1;

      for (int j = 0; j < PHASE_WORDS; j++) begin
        if ($urandom_range(0, 6) == 0) begin
          send_branch($urandom(), 1'($urandom_range(0, 1)));
        end else begin
          sel = $urandom_range(0, POOL_SIZE - 1);
          case (pool_habit[sel])
            HABIT_TAKEN:     dir = ($urandom_range(0, 9) != 0);
            HABIT_NOT_TAKEN: dir = ($urandom_range(0, 9) == 0);
            HABIT_ALTERNATE: dir = !last_dir[sel];
            default:         dir = 1'($urandom_range(0, 1));
          endcase
          last_dir[sel] = dir;
          send_branch({pool_addr[sel][31:2], 2'($urandom_range(0, 3))}, dir);
        end
      end
      drain();
    end

    repeat (12) @(posedge clk);
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

endmodule

@@ hybrid_branch_predictor_top.f @@
design/hbp_pkg.sv
design/hbp_counter_ram.sv
design/hbp_index.sv
design/hbp_update.sv
design/hybrid_branch_predictor_top.sv
design/hbp_checker.sv
tb/sv/hbp_checker.sv
tb/sv/tb_top.sv
